>>> sv/modbus_register_value_decoder_defines.svh
// Assertion macros shared by the decoder RTL.
`ifndef MODBUS_REGISTER_VALUE_DECODER_DEFINES_SVH
`define MODBUS_REGISTER_VALUE_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MRVD_ASSERT_NOW(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("decoder assertion failed");

// Next-cycle implication, checked outside reset.
`define MRVD_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("decoder assertion failed");

`endif

>>> sv/mrvd_pkg.sv
// Types and codes for the Modbus register value decoder.
package mrvd_pkg;

  // Data type codes.
  localparam logic [3:0] OP_UINT16   = 4'd0;
  localparam logic [3:0] OP_INT16    = 4'd1;
  localparam logic [3:0] OP_BOOL     = 4'd2;
  localparam logic [3:0] OP_INT32    = 4'd3;
  localparam logic [3:0] OP_UINT32   = 4'd4;
  localparam logic [3:0] OP_FLOAT32  = 4'd5;
  localparam logic [3:0] OP_INT64    = 4'd6;
  localparam logic [3:0] OP_UINT64   = 4'd7;
  localparam logic [3:0] OP_DOUBLE64 = 4'd8;

  // Byte and word order codes.
  localparam logic [1:0] ORD_ABCD = 2'd0;
  localparam logic [1:0] ORD_DCBA = 2'd1;
  localparam logic [1:0] ORD_BADC = 2'd2;
  localparam logic [1:0] ORD_CDAB = 2'd3;

  // Exponent biases for the conversion paths.
  localparam logic [10:0] INT_EXP_BASE = 11'd1086;
  localparam logic [10:0] SUB_EXP_BASE = 11'd937;
  localparam logic [10:0] F32_EXP_ADJ  = 11'd896;

  // Decoded item between the assembly and normalise stages.
  typedef struct packed {
    logic        direct;
    logic        f32sub;
    logic        sign;
    logic [63:0] mag;
    logic [63:0] bits;
  } dec_t;

endpackage

>>> sv/mrvd_order.sv
// Register word and byte reordering for 32-bit and 64-bit groups.
module mrvd_order (
  input  logic [1:0]  byte_order,
  input  logic [15:0] word0,
  input  logic [15:0] word1,
  input  logic [15:0] word2,
  input  logic [15:0] word3,
  output logic [31:0] o32,
  output logic [63:0] o64
);
  import mrvd_pkg::*;

  logic [31:0] v32;
  logic [63:0] v64;

  assign v32 = {word0, word1};
  assign v64 = {word0, word1, word2, word3};

  // Select the assembly order for both widths.
  always_comb begin
    case (byte_order)
      ORD_DCBA: begin
        for (int i = 0; i < 4; i++) o32[8*i +: 8] = v32[8*(3-i) +: 8];
        for (int i = 0; i < 8; i++) o64[8*i +: 8] = v64[8*(7-i) +: 8];
      end
      ORD_BADC: begin
        for (int i = 0; i < 2; i++) o32[16*i +: 16] = {v32[16*i +: 8], v32[16*i+8 +: 8]};
        for (int i = 0; i < 4; i++) o64[16*i +: 16] = {v64[16*i +: 8], v64[16*i+8 +: 8]};
      end
      ORD_CDAB: begin
        o32 = {word1, word0};
        o64 = {word3, word2, word1, word0};
      end
      default: begin
        o32 = v32;
        o64 = v64;
      end
    endcase
  end
endmodule

>>> sv/modbus_register_value_decoder.sv
// Pipeline: input register, assembly, leading-zero count and normalise/round stages, in order.
// Throughput: one transaction per cycle while the receiver keeps m_tready high; each
// stage stalls only when full.
// Reset: synchronous active-high rst empties every stage; payload registers are not reset.
// A held result does not block input while earlier stages still have room.
module modbus_register_value_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // op[3:0], byte_order[5:4], word0[21:6], word1[37:22], word2[53:38], word3[69:54]
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // value_bits[63:0]
  output logic [63:0] m_tdata
);
  import mrvd_pkg::*;
  `include "modbus_register_value_decoder_defines.svh"

  logic        v0, v1, v2, v3;
  logic        rdy1, rdy2, rdy3;
  logic [3:0]  op;
  logic [1:0]  ord;
  logic [15:0] w0, w1, w2, w3;
  logic [31:0] o32;
  logic [63:0] o64;
  dec_t        dec_next, d1, d2;
  logic [5:0]  lz_next, lz;
  logic        zero_next, zero;
  logic [63:0] res_next, res;

  // Stage handshake chain.
  assign rdy3     = !v3 || m_tready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = !v0 || rdy1;
  assign m_tvalid = v3;
  assign m_tdata  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (s_tready) v0 <= s_tvalid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_tready) begin
      op  <= s_tdata[3:0];
      ord <= s_tdata[5:4];
      w0  <= s_tdata[21:6];
      w1  <= s_tdata[37:22];
      w2  <= s_tdata[53:38];
      w3  <= s_tdata[69:54];
    end
    if (rdy1) d1 <= dec_next;
    if (rdy2) begin
      d2   <= d1;
      lz   <= lz_next;
      zero <= zero_next;
    end
    if (rdy3) res <= res_next;
  end

  mrvd_order u_order (
    .byte_order(ord),
    .word0(w0),
    .word1(w1),
    .word2(w2),
    .word3(w3),
    .o32(o32),
    .o64(o64)
  );

  // Assembly: turn each type into a sign and magnitude, or a finished pattern.
  always_comb begin
    dec_next = '0;
    unique case (op)
      OP_INT16: begin
        dec_next.sign = w0[15];
        dec_next.mag  = w0[15] ? {47'b0, 17'h10000 - {1'b0, w0}} : {48'b0, w0};
      end
      OP_BOOL: dec_next.mag = {63'b0, (w0 != 16'd0)};
      OP_INT32: begin
        dec_next.sign = o32[31];
        dec_next.mag  = o32[31] ? {32'b0, ~o32 + 32'd1} : {32'b0, o32};
      end
      OP_UINT32: dec_next.mag = {32'b0, o32};
      OP_FLOAT32: begin
        if (o32[30:23] == 8'hFF) begin
          dec_next.direct = 1'b1;
          dec_next.bits   = {o32[31], 11'h7FF, o32[22] | (o32[22:0] != 23'd0),
                             o32[21:0], 29'b0};
        end else if (o32[30:23] == 8'd0) begin
          if (o32[22:0] == 23'd0) begin
            dec_next.direct = 1'b1;
            dec_next.bits   = {o32[31], 63'b0};
          end else begin
            dec_next.f32sub = 1'b1;
            dec_next.sign   = o32[31];
            dec_next.mag    = {41'b0, o32[22:0]};
          end
        end else begin
          dec_next.direct = 1'b1;
          dec_next.bits   = {o32[31], {3'b0, o32[30:23]} + F32_EXP_ADJ, o32[22:0], 29'b0};
        end
      end
      OP_INT64: begin
        dec_next.sign = o64[63];
        dec_next.mag  = o64[63] ? ~o64 + 64'd1 : o64;
      end
      OP_UINT64: dec_next.mag = o64;
      OP_DOUBLE64: begin
        dec_next.direct = 1'b1;
        dec_next.bits   = o64;
      end
      default: dec_next.mag = {48'b0, w0};
    endcase
  end

  // Leading-zero count of the magnitude.
  always_comb begin
    lz_next   = '0;
    zero_next = (d1.mag == 64'd0);
    for (int i = 0; i < 64; i++) begin
      if (d1.mag[i]) lz_next = 6'(63 - i);
    end
  end

  // Normalise and round to nearest even.
  logic [63:0] norm;
  logic [62:0] em;
  logic        rnd;
  always_comb begin
    norm = d2.mag << lz;
    em   = {INT_EXP_BASE - {5'b0, lz}, norm[62:11]};
    rnd  = norm[10] && ((norm[9:0] != 10'd0) || norm[11]);
    if (d2.direct) begin
      res_next = d2.bits;
    end else if (d2.f32sub) begin
      res_next = {d2.sign, SUB_EXP_BASE - {5'b0, lz}, norm[62:40], 29'b0};
    end else if (zero) begin
      res_next = 64'd0;
    end else begin
      res_next = {d2.sign, em + {62'b0, rnd}};
    end
  end

  `MRVD_ASSERT_NOW(a_ready_when_drained, m_tready, s_tready)
  `MRVD_ASSERT_NEXT(a_accept_fills_input, s_tvalid && s_tready, v0)
  `MRVD_ASSERT_NEXT(a_result_held, v3 && !m_tready, v3)
endmodule

>>> test/modbus_register_value_decoder_checker.sv
// Checker that predicts and compares the decoded double for each transaction.
`timescale 1ns / 100ps

module modbus_register_value_decoder_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  output int          errors,
  output int          pending
);
  import mrvd_pkg::*;

  // Ring of predicted results, indexed by running write and read counts.
  logic [63:0] expected_values [64];
  int          wr_count;
  int          rd_count;

  // Reorder the two-word group as the order code asks.
  function automatic logic [31:0] arrange32(logic [15:0] w0, logic [15:0] w1,
                                            logic [1:0] ord);
    logic [31:0] v;
    v = {w0, w1};
    case (ord)
      ORD_DCBA: return {v[7:0], v[15:8], v[23:16], v[31:24]};
      ORD_BADC: return {v[23:16], v[31:24], v[7:0], v[15:8]};
      ORD_CDAB: return {w1, w0};
      default:  return v;
    endcase
  endfunction

  // Reorder the four-word group as the order code asks.
  function automatic logic [63:0] arrange64(logic [15:0] w0, logic [15:0] w1,
                                            logic [15:0] w2, logic [15:0] w3,
                                            logic [1:0] ord);
    logic [63:0] v;
    logic [63:0] r;
    v = {w0, w1, w2, w3};
    r = '0;
    case (ord)
      ORD_DCBA: begin
        for (int i = 0; i < 8; i++) r[8*(7-i) +: 8] = v[8*i +: 8];
        return r;
      end
      ORD_BADC: begin
        for (int i = 0; i < 4; i++) r[16*i +: 16] = {v[16*i +: 8], v[16*i+8 +: 8]};
        return r;
      end
      ORD_CDAB: return {w3, w2, w1, w0};
      default:  return v;
    endcase
  endfunction

  // Unsigned magnitude to double, rounded to nearest with ties to even.
  function automatic logic [63:0] magnitude_to_double(logic sgn, logic [63:0] mag);
    int lead;
    logic [63:0] norm;
    logic [52:0] mant;
    logic [10:0] guard;
    logic [11:0] expo;
    logic [53:0] sum;
    if (mag == 0) return {sgn, 63'd0};
    lead = 63;
    while (!mag[lead]) lead--;
    norm = mag << (63 - lead);
    mant = norm[63:11];
    guard = norm[10:0];
    expo = 12'(1023 + lead);
    sum = {1'b0, mant};
    // Round up above the half, or at the half when the kept part is odd.
    if (guard[10] && (guard[9:0] != 0 || mant[0])) sum = sum + 1;
    if (sum[53]) begin
      sum = sum >> 1;
      expo = expo + 1;
    end
    return {sgn, expo[10:0], sum[51:0]};
  endfunction

  // Widen a single-precision pattern to double precision.
  function automatic logic [63:0] widen_single(logic [31:0] b);
    logic [7:0] e;
    logic [22:0] m;
    int ex;
    e = b[30:23];
    m = b[22:0];
    if (e == 8'hFF) begin
      if (m == 0) return {b[31], 11'h7FF, 52'd0};
      return {b[31], 11'h7FF, 1'b1, m[21:0], 29'd0};
    end
    if (e == 0) begin
      if (m == 0) return {b[31], 63'd0};
      // Subnormal: shift the leading one out, one exponent step per shift.
      ex = 0;
      while (!m[22]) begin
        m = m << 1;
        ex--;
      end
      m = m << 1;
      return {b[31], 11'(ex + 896), m, 29'd0};
    end
    return {b[31], 11'(e + 896), m, 29'd0};
  endfunction

  // Decoded value of one input transaction.
  function automatic logic [63:0] decode_value(logic [71:0] d);
    logic [3:0] op;
    logic [1:0] ord;
    logic [15:0] w0, w1, w2, w3;
    logic [31:0] c32;
    logic [63:0] c64;
    op = d[3:0];
    ord = d[5:4];
    w0 = d[21:6];
    w1 = d[37:22];
    w2 = d[53:38];
    w3 = d[69:54];
    case (op)
      OP_INT16:
        return magnitude_to_double(w0[15], w0[15] ? {48'd0, 16'(-w0)} : {48'd0, w0});
      OP_BOOL: return magnitude_to_double(1'b0, 64'(w0 != 0));
      OP_INT32: begin
        c32 = arrange32(w0, w1, ord);
        return magnitude_to_double(c32[31], c32[31] ? {32'd0, 32'(-c32)} : {32'd0, c32});
      end
      OP_UINT32: return magnitude_to_double(1'b0, 64'(arrange32(w0, w1, ord)));
      OP_FLOAT32: return widen_single(arrange32(w0, w1, ord));
      OP_INT64: begin
        c64 = arrange64(w0, w1, w2, w3, ord);
        return magnitude_to_double(c64[63], c64[63] ? -c64 : c64);
      end
      OP_UINT64: return magnitude_to_double(1'b0, arrange64(w0, w1, w2, w3, ord));
      OP_DOUBLE64: return arrange64(w0, w1, w2, w3, ord);
      default: return magnitude_to_double(1'b0, 64'(w0));
    endcase
  endfunction

  assign pending = wr_count - rd_count;

  // Record predictions and compare results at each rising edge.
  always @(posedge clk) begin
    if (rst) begin
      errors <= 0;
      wr_count <= 0;
      rd_count <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_values[wr_count % 64] <= decode_value(s_tdata);
        wr_count <= wr_count + 1;
      end
      if (m_tvalid && m_tready) begin
        if (wr_count == rd_count) begin
          $error("value_bits: no transaction expected, actual %h", m_tdata);
          errors <= errors + 1;
        end else begin
          if (expected_values[rd_count % 64] !== m_tdata) begin
            $error("value_bits: expected %h, actual %h", expected_values[rd_count % 64],
                   m_tdata);
            errors <= errors + 1;
          end
          rd_count <= rd_count + 1;
        end
      end
    end
  end
endmodule

>>> test/modbus_register_value_decoder_test.sv
// Top level of the decoder testbench: stimulus, clock, reset and verdict.
`timescale 1ns / 100ps

module modbus_register_value_decoder_test;
  import mrvd_pkg::*;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [71:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [63:0] m_tdata;
  int errors;
  int pending;
  int cycles;
  int send_idle_pct;
  int recv_stall_pct;

  modbus_register_value_decoder u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  modbus_register_value_decoder_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Timeout guard on total cycles.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver stalls at random in the current phase.
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Pack one transaction.
  function automatic logic [71:0] pack_item(logic [3:0] op, logic [1:0] ord,
                                            logic [15:0] w0, logic [15:0] w1,
                                            logic [15:0] w2, logic [15:0] w3);
    return {2'b00, w3, w2, w1, w0, ord, op};
  endfunction

  // Offer one transaction and hold it until accepted.
  task automatic send_item(logic [71:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata <= d;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random word with a bias towards interesting edges.
  function automatic logic [15:0] rand_word();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7F80;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [3:0] op;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extremes, every type, every order, float special values.
    send_item(pack_item(OP_UINT16, ORD_ABCD, 16'hFFFF, 0, 0, 0));
    send_item(pack_item(OP_INT16, ORD_ABCD, 16'h8000, 0, 0, 0));
    send_item(pack_item(OP_INT16, ORD_ABCD, 16'h7FFF, 0, 0, 0));
    send_item(pack_item(OP_BOOL, ORD_ABCD, 16'h0000, 0, 0, 0));
    send_item(pack_item(OP_BOOL, ORD_DCBA, 16'h0100, 0, 0, 0));
    send_item(pack_item(OP_INT32, ORD_ABCD, 16'h8000, 16'h0000, 0, 0));
    send_item(pack_item(OP_UINT32, ORD_DCBA, 16'hFFFF, 16'hFFFF, 0, 0));
    send_item(pack_item(OP_FLOAT32, ORD_ABCD, 16'h7FC1, 16'h2345, 0, 0));
    send_item(pack_item(OP_FLOAT32, ORD_ABCD, 16'hFF80, 16'h0000, 0, 0));
    send_item(pack_item(OP_FLOAT32, ORD_CDAB, 16'h0001, 16'h8000, 0, 0));
    send_item(pack_item(OP_FLOAT32, ORD_BADC, 16'h4000, 16'h0000, 0, 0));
    send_item(pack_item(OP_INT64, ORD_ABCD, 16'h8000, 0, 0, 0));
    send_item(pack_item(OP_INT64, ORD_ABCD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(pack_item(OP_UINT64, ORD_ABCD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(pack_item(OP_UINT64, ORD_ABCD, 16'h0020, 16'h0000, 16'h0000, 16'h0400));
    send_item(pack_item(OP_UINT64, ORD_ABCD, 16'h0020, 16'h0000, 16'h0000, 16'h0C00));
    send_item(pack_item(OP_UINT64, ORD_ABCD, 16'h0020, 16'h0000, 16'h0000, 16'h0401));
    send_item(pack_item(OP_DOUBLE64, ORD_DCBA, 16'h0123, 16'h4567, 16'h89AB, 16'hCDEF));
    send_item(pack_item(OP_DOUBLE64, ORD_BADC, 16'h0123, 16'h4567, 16'h89AB, 16'hCDEF));
    send_item(pack_item(OP_DOUBLE64, ORD_CDAB, 16'h0123, 16'h4567, 16'h89AB, 16'hCDEF));
    send_item(pack_item(4'd9, ORD_ABCD, 16'h1234, 0, 0, 0));
    send_item(pack_item(4'd15, ORD_CDAB, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));

    // Random items over the idle and stall phases.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 82; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 82; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      for (int i = 0; i < 225; i++) begin
        op = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
        send_item(pack_item(op, 2'($urandom), rand_word(), rand_word(), rand_word(),
                            rand_word()));
      end
    end
    s_tvalid <= 1'b0;

    // Drain and settle.
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
